// ===== rtl/core/time_delay_embedder_core_defines.svh =====
// ----------------------------------------------------------------------------
// time_delay_embedder_core_defines
// assertion macros shared by the embedder rtl
// ----------------------------------------------------------------------------
`ifndef TIME_DELAY_EMBEDDER_CORE_DEFINES_SVH
`define TIME_DELAY_EMBEDDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk and off during reset
`define TDE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk and off during reset
`define TDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tde_pkg.sv =====
// ----------------------------------------------------------------------------
// tde_pkg
// shared types and constants of the time-delay embedder
// ----------------------------------------------------------------------------
`default_nettype none

package tde_pkg;

	// field widths of the words
	localparam int unsigned CHANNEL_W   = 2;
	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned LAG_IDX_W   = 3;
	localparam int unsigned DIMS_REG_W  = 4;
	localparam int unsigned LAG_REG_W   = 5;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// register reset values
	localparam logic [DIMS_REG_W-1:0] DIMS_RESET = 4'd2;
	localparam logic [LAG_REG_W-1:0]  LAG_RESET  = 5'd1;

	// register index, taken from the word address bit
	typedef enum logic {
		REG_EMBED_DIMS = 1'b0,
		REG_LAG_STEP   = 1'b1
	} reg_idx_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} seq_state_t;

	// input word
	typedef struct packed {
		logic [CHANNEL_W-1:0]       channel;
		logic signed [SAMPLE_W-1:0] sample;
	} in_word_t;

	// result word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [CHANNEL_W-1:0]       out_channel;
		logic [LAG_IDX_W-1:0]       lag_index;
		logic                       last;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/time_delay_embedder_core.sv =====
// The first result of an emitting sample passes the sequencer state, the read stage and the output register.
// An emitting sample stalls the sample channel until its last coordinate has left the read stage, with one
// history read per coordinate past coordinate zero through the single read port of the history memory.
// Reset: write pointers, row counts and control clear at once; the history memory is not
// cleared, its entries are only read after being written.
`include "time_delay_embedder_core_defines.svh"
`default_nettype none

// ----------------------------------------------------------------------------
// time_delay_embedder_core
// streaming delay embedder: per-channel sample rings in one memory; unless the result
// channel stalls, one lagged coordinate read per cycle
// ----------------------------------------------------------------------------
module time_delay_embedder_core #(
	parameter int unsigned NUM_CHANNELS  = 4,
	parameter int unsigned MAX_DIMS      = 8,
	parameter int unsigned MAX_LAG       = 16,
	parameter int unsigned HISTORY_DEPTH = 128
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// sample channel
	input  wire                                  sample_valid,
	output logic                                 sample_stall,
	input  tde_pkg::in_word_t                    sample_word,
	// result channel
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output tde_pkg::out_word_t                   result_word,
	// register port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [tde_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire  [tde_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [tde_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	import tde_pkg::*;

	localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int unsigned DIM_W  = $clog2(MAX_DIMS + 1);
	localparam int unsigned LAG_W  = $clog2(MAX_LAG + 1);
	localparam int unsigned E_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int unsigned NEED_W = LAG_W + DIM_W;

	// register file
	logic [DIMS_REG_W-1:0] embed_dims_q;
	logic [LAG_REG_W-1:0]  lag_step_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	// per-channel pointers and counts
	logic [PTR_W-1:0] wp_q   [NUM_CHANNELS];
	logic [PTR_W-1:0] seen_q [NUM_CHANNELS];

	// history memory
	logic [SAMPLE_W-1:0] hist_mem_q [NUM_CHANNELS][HISTORY_DEPTH];
	logic [SAMPLE_W-1:0] rdata_s1;

	// sequencer
	seq_state_t          state_q, state_nxt;
	logic [CH_W-1:0]     ch_q;
	logic [DIM_W-1:0]    dims_q;
	logic [LAG_W-1:0]    lag_q;
	logic [E_W-1:0]      e_q;
	logic [PTR_W-1:0]    off_q;
	logic [PTR_W-1:0]    wp_item_q;
	logic [SAMPLE_W-1:0] sample_q;

	// read stage
	logic            pend_s1;
	logic            fwd_s1;
	logic [E_W-1:0]  e_s1;
	logic            last_s1;
	logic [CH_W-1:0] ch_s1;

	// output register
	out_word_t out_q;
	logic      out_valid_q;

	// combinational
	logic [31:0]       ch_wide;
	logic [CH_W-1:0]   ch_idx;
	logic              ch_ok;
	logic              accept;
	logic              wr_en;
	logic [31:0]       dims_raw;
	logic [31:0]       lag_raw;
	logic [DIM_W-1:0]  dims_c;
	logic [LAG_W-1:0]  lag_c;
	logic [NEED_W-1:0] need;
	logic [PTR_W-1:0]  wp_cur;
	logic [PTR_W-1:0]  wp_next;
	logic [PTR_W-1:0]  seen_next;
	logic              emit_now;
	logic              issue;
	logic              rd_en;
	logic              is_last_e;
	logic              pend_move;
	logic [PTR_W:0]    slot_wide;
	logic [PTR_W-1:0]  slot;
	logic [PTR_W:0]    off_sum;
	logic [31:0]       e_wide;

	// register write decode
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			embed_dims_q <= DIMS_RESET;
			lag_step_q   <= LAG_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_EMBED_DIMS: embed_dims_q <= pwdata[DIMS_REG_W-1:0];
				REG_LAG_STEP:   lag_step_q   <= pwdata[LAG_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read mux
	always_comb begin
		unique case (cfg_idx)
			REG_EMBED_DIMS: prdata = APB_DATA_W'(embed_dims_q);
			REG_LAG_STEP:   prdata = APB_DATA_W'(lag_step_q);
			default:        prdata = '0;
		endcase
	end

	// clamp settings to their legal range
	always_comb begin
		dims_raw = 32'(embed_dims_q);
		lag_raw  = 32'(lag_step_q);
		if (dims_raw == 32'd0)
			dims_c = DIM_W'(1);
		else if (dims_raw > MAX_DIMS)
			dims_c = DIM_W'(MAX_DIMS);
		else
			dims_c = dims_raw[DIM_W-1:0];
		if (lag_raw == 32'd0)
			lag_c = LAG_W'(1);
		else if (lag_raw > MAX_LAG)
			lag_c = LAG_W'(MAX_LAG);
		else
			lag_c = lag_raw[LAG_W-1:0];
	end

	// channel decode and row bookkeeping for the incoming sample
	always_comb begin
		ch_wide   = 32'(sample_word.channel);
		ch_idx    = ch_wide[CH_W-1:0];
		ch_ok     = ch_wide < NUM_CHANNELS;
		wp_cur    = wp_q[ch_idx];
		wp_next   = (32'(wp_cur) == HISTORY_DEPTH - 1) ? '0 : wp_cur + 1'b1;
		seen_next = (32'(seen_q[ch_idx]) < HISTORY_DEPTH - 1) ? seen_q[ch_idx] + 1'b1
			: seen_q[ch_idx];
		need      = NEED_W'(lag_c) * NEED_W'(dims_c - 1'b1) + NEED_W'(1);
		emit_now  = 32'(seen_next) >= 32'(need);
	end

	// ring slot of the current coordinate, modulo the ring depth
	always_comb begin
		if (off_q > wp_item_q)
			slot_wide = {1'b0, wp_item_q} + (PTR_W+1)'(HISTORY_DEPTH) - {1'b0, off_q};
		else
			slot_wide = {1'b0, wp_item_q} - {1'b0, off_q};
		slot    = slot_wide[PTR_W-1:0];
		off_sum = {1'b0, off_q} + (PTR_W+1)'(lag_q);
	end

	assign pend_move = pend_s1 & (~out_valid_q | ~result_stall);
	assign is_last_e = (32'(e_q) + 32'd1) == 32'(dims_q);

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && ch_ok && emit_now) state_nxt = ST_EMIT;
			ST_EMIT: if (issue && is_last_e) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_stall = 1'b1;
		issue        = 1'b0;
		unique case (state_q)
			ST_IDLE: sample_stall = pend_s1;
			ST_EMIT: issue        = ~pend_s1 | pend_move;
			default: ;
		endcase
		accept = sample_valid & ~sample_stall;
		wr_en  = accept & ch_ok;
		rd_en  = issue & (e_q != '0);
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q     <= '0;
			off_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				e_q   <= '0;
				off_q <= '0;
			end else if (issue) begin
				e_q   <= e_q + 1'b1;
				off_q <= off_sum[PTR_W-1:0];
			end
		end
	end

	// item context captured at accept
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ch_q      <= ch_idx;
			dims_q    <= dims_c;
			lag_q     <= lag_c;
			wp_item_q <= wp_cur;
			sample_q  <= sample_word.sample;
		end
	end

	// per-channel write pointer and row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wp_q[i]   <= '0;
				seen_q[i] <= '0;
			end
		end else if (wr_en) begin
			wp_q[ch_idx]   <= wp_next;
			seen_q[ch_idx] <= seen_next;
		end
	end

	// history memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			hist_mem_q[ch_idx][wp_cur] <= sample_word.sample;
		if (rd_en)
			rdata_s1 <= hist_mem_q[ch_q][slot];
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_s1 <= 1'b0;
		else if (issue)
			pend_s1 <= 1'b1;
		else if (pend_move)
			pend_s1 <= 1'b0;
	end

	// read stage tags, coordinate zero comes from the captured sample
	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_s1  <= (e_q == '0);
			e_s1    <= e_q;
			last_s1 <= is_last_e;
			ch_s1   <= ch_q;
		end
	end

	assign e_wide = 32'(e_s1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pend_move)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_q.value       <= fwd_s1 ? sample_q : rdata_s1;
			out_q.out_channel <= CHANNEL_W'(ch_s1);
			out_q.lag_index   <= e_wide[LAG_IDX_W-1:0];
			out_q.last        <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

	// checks
	`TDE_ASSERT_IMPL(a_no_overrun, issue && pend_s1, pend_move,
		"read issued while the read stage holds an unmoved word")
	`TDE_ASSERT_IMPL(a_read_in_emit, rd_en, state_q == ST_EMIT && e_q != '0,
		"history read outside coordinate sequencing")
	`TDE_ASSERT_NEXT(a_emit_start, wr_en && emit_now, state_q == ST_EMIT && e_q == '0,
		"emitting sample did not start at coordinate zero")

endmodule

`default_nettype wire
